/* design/eppa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eppa_pkg
// Types, constants and the saturating step function shared by the PWM
// parameter adjuster.
// ----------------------------------------------------------------------------
package eppa_pkg;

    localparam int unsigned FREQ_W  = 22;
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned DEAD_W  = 13;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned FSTEP_W = 16;
    localparam int unsigned CFG_W   = 22;
    localparam int unsigned CIDX_W  = 3;

    typedef enum logic [1:0] {
        OP_FREQ   = 2'd0,
        OP_DUTY   = 2'd1,
        OP_DEAD   = 2'd2,
        OP_TOGGLE = 2'd3
    } t_opcode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FREQ_FINE   = 3'd0,
        CFG_FREQ_COARSE = 3'd1,
        CFG_DUTY_FINE   = 3'd2,
        CFG_DUTY_COARSE = 3'd3,
        CFG_DEAD_FINE   = 3'd4,
        CFG_DEAD_COARSE = 3'd5,
        CFG_FREQ_UPPER  = 3'd6,
        CFG_DEAD_UPPER  = 3'd7
    } t_cfg_index;

    typedef struct packed {
        t_opcode opcode;
        logic    qualified;
        logic    increase;
        logic    coarse;
        logic    preset_first;
        logic    preset_second;
    } t_in_item;

    typedef struct packed {
        logic               active_set;
        logic [FREQ_W-1:0]  frequency;
        logic [DUTY_W-1:0]  duty;
        logic [DEAD_W-1:0]  dead_time;
        logic [COUNT_W-1:0] change_count;
    } t_out_item;

    typedef struct packed {
        logic [FSTEP_W-1:0] freq_fine_step;
        logic [FSTEP_W-1:0] freq_coarse_step;
        logic [DUTY_W-1:0]  duty_fine_step;
        logic [DUTY_W-1:0]  duty_coarse_step;
        logic [DEAD_W-1:0]  dead_fine_step;
        logic [DEAD_W-1:0]  dead_coarse_step;
        logic [FREQ_W-1:0]  freq_upper_limit;
        logic [DEAD_W-1:0]  dead_upper_limit;
    } t_cfg;

    // Register reset values.
    localparam logic [FSTEP_W-1:0] RST_FREQ_FINE   = 16'd10;
    localparam logic [FSTEP_W-1:0] RST_FREQ_COARSE = 16'd1000;
    localparam logic [DUTY_W-1:0]  RST_DUTY_FINE   = 7'd1;
    localparam logic [DUTY_W-1:0]  RST_DUTY_COARSE = 7'd5;
    localparam logic [DEAD_W-1:0]  RST_DEAD_FINE   = 13'd5;
    localparam logic [DEAD_W-1:0]  RST_DEAD_COARSE = 13'd50;
    localparam logic [FREQ_W-1:0]  RST_FREQ_UPPER  = 22'd2500000;
    localparam logic [DEAD_W-1:0]  RST_DEAD_UPPER  = 13'd6000;

    // Parameter set reset values.
    localparam logic [FREQ_W-1:0] RST_FREQ_FIRST  = 22'd2000;
    localparam logic [FREQ_W-1:0] RST_FREQ_SECOND = 22'd3000;
    localparam logic [DUTY_W-1:0] RST_DUTY_FIRST  = 7'd50;
    localparam logic [DUTY_W-1:0] RST_DUTY_SECOND = 7'd40;
    localparam logic [DEAD_W-1:0] RST_DEAD_FIRST  = 13'd0;
    localparam logic [DEAD_W-1:0] RST_DEAD_SECOND = 13'd5;

    // Presets loaded by a toggle.
    localparam logic [FREQ_W-1:0] PRE_FREQ        = 22'd60000;
    localparam logic [DUTY_W-1:0] PRE_DUTY_FIRST  = 7'd50;
    localparam logic [DUTY_W-1:0] PRE_DUTY_SECOND = 7'd49;
    localparam logic [DEAD_W-1:0] PRE_DEAD_FIRST  = 13'd6;
    localparam logic [DEAD_W-1:0] PRE_DEAD_SECOND = 13'd10;

    // Field limits.
    localparam logic [FREQ_W-1:0] FREQ_FLOOR = 22'd10;
    localparam logic [FREQ_W-1:0] DUTY_FLOOR = 22'd2;
    localparam logic [FREQ_W-1:0] DUTY_CEIL  = 22'd99;
    localparam logic [FREQ_W-1:0] DEAD_FLOOR = 22'd0;

    localparam logic [COUNT_W-1:0] COUNT_WRAP    = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_RESTART = 7'd1;

    // One saturating step on a value held in the widest field width.
    // A decrease that would pass the floor, or a value already below it,
    // lands on the floor.
    function automatic logic [FREQ_W-1:0] f_move(
        input logic [FREQ_W-1:0]  v,
        input logic [FSTEP_W-1:0] step,
        input logic               up,
        input logic [FREQ_W-1:0]  lo,
        input logic [FREQ_W-1:0]  hi
    );
        logic [FREQ_W:0]   sum;
        logic [FREQ_W-1:0] above;
        logic [FREQ_W-1:0] step_x;
        logic [FREQ_W-1:0] res;
        step_x = {{(FREQ_W-FSTEP_W){1'b0}}, step};
        sum    = {1'b0, v} + {1'b0, step_x};
        above  = v - lo;
        if (up) begin
            res = (sum > {1'b0, hi}) ? hi : sum[FREQ_W-1:0];
        end else if ((v < lo) || (above < step_x)) begin
            res = lo;
        end else begin
            res = v - step_x;
        end
        return res;
    endfunction

endpackage : eppa_pkg
`default_nettype wire

/* design/encoder_pwm_parameter_adjuster_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_pwm_parameter_adjuster_core
// Two-set PWM parameter adjuster driven by rotary-encoder events.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one event per
// beat: adjust frequency, duty or dead time of the active set, or toggle
// the active set with optional preset loads. Every event yields exactly one
// result beat on the output channel (o_out_valid / i_out_ready /
// o_out_data) showing the active set's values and the change counter after
// that event.
// An event is captured in an input register, applied to the parameter
// state, and the outcome lands in the result register. Throughput is one
// event per cycle while i_out_ready stays high; the state update is a
// single saturating add or subtract per adjust event. Step sizes and
// ceilings go in through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write them only while no event is in flight; no check enforces it.
// Reset restores the default steps, ceilings, both parameter sets and a
// zero change counter, and empties both registers. When the receiver
// stalls, the result is held and the pending event waits in the input
// register; o_in_ready drops only when both registers are occupied.
// ----------------------------------------------------------------------------
module encoder_pwm_parameter_adjuster_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire eppa_pkg::t_in_item           i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output eppa_pkg::t_out_item               o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [eppa_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [eppa_pkg::CFG_W-1:0]   i_cfg_data
);
    import eppa_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;

    // An event moves on when the result register is empty or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    eppa_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    eppa_param_core u_param_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule : encoder_pwm_parameter_adjuster_core
`default_nettype wire

/* design/eppa_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eppa_cfg_regs
// Step sizes and ceilings, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module eppa_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [eppa_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire logic [eppa_pkg::CFG_W-1:0]   i_cfg_data,
    output eppa_pkg::t_cfg                    o_cfg
);
    import eppa_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq_fine_step   <= RST_FREQ_FINE;
            r_cfg.freq_coarse_step <= RST_FREQ_COARSE;
            r_cfg.duty_fine_step   <= RST_DUTY_FINE;
            r_cfg.duty_coarse_step <= RST_DUTY_COARSE;
            r_cfg.dead_fine_step   <= RST_DEAD_FINE;
            r_cfg.dead_coarse_step <= RST_DEAD_COARSE;
            r_cfg.freq_upper_limit <= RST_FREQ_UPPER;
            r_cfg.dead_upper_limit <= RST_DEAD_UPPER;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FREQ_FINE:   r_cfg.freq_fine_step   <= i_cfg_data[FSTEP_W-1:0];
                CFG_FREQ_COARSE: r_cfg.freq_coarse_step <= i_cfg_data[FSTEP_W-1:0];
                CFG_DUTY_FINE:   r_cfg.duty_fine_step   <= i_cfg_data[DUTY_W-1:0];
                CFG_DUTY_COARSE: r_cfg.duty_coarse_step <= i_cfg_data[DUTY_W-1:0];
                CFG_DEAD_FINE:   r_cfg.dead_fine_step   <= i_cfg_data[DEAD_W-1:0];
                CFG_DEAD_COARSE: r_cfg.dead_coarse_step <= i_cfg_data[DEAD_W-1:0];
                CFG_FREQ_UPPER:  r_cfg.freq_upper_limit <= i_cfg_data[FREQ_W-1:0];
                CFG_DEAD_UPPER:  r_cfg.dead_upper_limit <= i_cfg_data[DEAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule : eppa_cfg_regs
`default_nettype wire

/* design/eppa_param_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// eppa_param_core
// Holds both parameter sets, the set selector and the change counter, and
// works out the state and the result that one event leaves.
// ----------------------------------------------------------------------------
module eppa_param_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire eppa_pkg::t_in_item i_item,
    input  wire eppa_pkg::t_cfg     i_cfg,
    output eppa_pkg::t_out_item     o_result
);
    import eppa_pkg::*;

    logic               r_set_sel,     n_set_sel;
    logic [FREQ_W-1:0]  r_freq_first,  n_freq_first;
    logic [FREQ_W-1:0]  r_freq_second, n_freq_second;
    logic [DUTY_W-1:0]  r_duty_first,  n_duty_first;
    logic [DUTY_W-1:0]  r_duty_second, n_duty_second;
    logic [DEAD_W-1:0]  r_dead_first,  n_dead_first;
    logic [DEAD_W-1:0]  r_dead_second, n_dead_second;
    logic [COUNT_W-1:0] r_count,       n_count;

    logic [COUNT_W-1:0] count_inc;
    logic [FREQ_W-1:0]  freq_moved;
    logic [FREQ_W-1:0]  duty_moved;
    logic [FREQ_W-1:0]  dead_moved;
    logic [FSTEP_W-1:0] freq_step;
    logic [FSTEP_W-1:0] duty_step;
    logic [FSTEP_W-1:0] dead_step;

    assign freq_step = i_item.coarse ? i_cfg.freq_coarse_step : i_cfg.freq_fine_step;
    assign duty_step = {{(FSTEP_W-DUTY_W){1'b0}},
                        i_item.coarse ? i_cfg.duty_coarse_step : i_cfg.duty_fine_step};
    assign dead_step = {{(FSTEP_W-DEAD_W){1'b0}},
                        i_item.coarse ? i_cfg.dead_coarse_step : i_cfg.dead_fine_step};

    assign freq_moved = f_move(r_set_sel ? r_freq_second : r_freq_first,
                               freq_step, i_item.increase, FREQ_FLOOR,
                               i_cfg.freq_upper_limit);
    assign duty_moved = f_move({{(FREQ_W-DUTY_W){1'b0}},
                                r_set_sel ? r_duty_second : r_duty_first},
                               duty_step, i_item.increase, DUTY_FLOOR, DUTY_CEIL);
    assign dead_moved = f_move({{(FREQ_W-DEAD_W){1'b0}},
                                r_set_sel ? r_dead_second : r_dead_first},
                               dead_step, i_item.increase, DEAD_FLOOR,
                               {{(FREQ_W-DEAD_W){1'b0}}, i_cfg.dead_upper_limit});

    // The counter skips zero when it wraps.
    assign count_inc = (r_count + 7'd1 == COUNT_WRAP) ? COUNT_RESTART : r_count + 7'd1;

    always_comb begin
        n_set_sel     = r_set_sel;
        n_freq_first  = r_freq_first;
        n_freq_second = r_freq_second;
        n_duty_first  = r_duty_first;
        n_duty_second = r_duty_second;
        n_dead_first  = r_dead_first;
        n_dead_second = r_dead_second;
        n_count       = r_count;
        case (i_item.opcode)
            OP_TOGGLE: begin
                if (i_item.qualified) begin
                    n_set_sel = ~r_set_sel;
                    if (i_item.preset_first) begin
                        n_freq_first = PRE_FREQ;
                        n_duty_first = PRE_DUTY_FIRST;
                        n_dead_first = PRE_DEAD_FIRST;
                    end
                    if (i_item.preset_second) begin
                        n_freq_second = PRE_FREQ;
                        n_duty_second = PRE_DUTY_SECOND;
                        n_dead_second = PRE_DEAD_SECOND;
                    end
                    n_count = count_inc;
                end
            end
            OP_FREQ: begin
                if (i_item.qualified) begin
                    if (r_set_sel) n_freq_second = freq_moved;
                    else           n_freq_first  = freq_moved;
                end
                n_count = count_inc;
            end
            OP_DUTY: begin
                if (i_item.qualified) begin
                    if (r_set_sel) n_duty_second = duty_moved[DUTY_W-1:0];
                    else           n_duty_first  = duty_moved[DUTY_W-1:0];
                end
                n_count = count_inc;
            end
            OP_DEAD: begin
                if (i_item.qualified) begin
                    if (r_set_sel) n_dead_second = dead_moved[DEAD_W-1:0];
                    else           n_dead_first  = dead_moved[DEAD_W-1:0];
                end
                n_count = count_inc;
            end
            default: begin
            end
        endcase

        o_result.active_set   = n_set_sel;
        o_result.frequency    = n_set_sel ? n_freq_second : n_freq_first;
        o_result.duty         = n_set_sel ? n_duty_second : n_duty_first;
        o_result.dead_time    = n_set_sel ? n_dead_second : n_dead_first;
        o_result.change_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_sel     <= 1'b0;
            r_freq_first  <= RST_FREQ_FIRST;
            r_freq_second <= RST_FREQ_SECOND;
            r_duty_first  <= RST_DUTY_FIRST;
            r_duty_second <= RST_DUTY_SECOND;
            r_dead_first  <= RST_DEAD_FIRST;
            r_dead_second <= RST_DEAD_SECOND;
            r_count       <= '0;
        end else if (i_advance) begin
            r_set_sel     <= n_set_sel;
            r_freq_first  <= n_freq_first;
            r_freq_second <= n_freq_second;
            r_duty_first  <= n_duty_first;
            r_duty_second <= n_duty_second;
            r_dead_first  <= n_dead_first;
            r_dead_second <= n_dead_second;
            r_count       <= n_count;
        end
    end

endmodule : eppa_param_core
`default_nettype wire
